// ===== rtl/core/matrix_3x3_inverse_defines.svh =====
// Assertion macros shared by the checker of the 3x3 matrix inverse.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef MATRIX_3X3_INVERSE_DEFINES_SVH
`define MATRIX_3X3_INVERSE_DEFINES_SVH
// Checked only outside reset.
`define M3I_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("m3i assertion failed");
// Checked at every edge, reset included.
`define M3I_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("m3i assertion failed");
`endif

// ===== rtl/core/m3i_pkg.sv =====
// Shared widths, types and the saturation function of the 3x3 matrix inverse.
// Used by m3i_div_pipe and matrix_3x3_inverse; depends on nothing.
`default_nettype none
package m3i_pkg;
  localparam int EW    = 32;  // entry width, Q16.16
  localparam int NE    = 9;   // entries per matrix
  localparam int AW    = 64;  // cofactor magnitude width
  localparam int MW    = 96;  // determinant magnitude width
  localparam int NSTEP = 32;  // quotient bits, one per divider stage

  typedef struct packed {
    logic [MW-1:0] dmag;
    logic          singular;
    logic [EW-1:0] det_value;
  } div_side_t;

  typedef struct packed {
    logic [AW-1:0] amag;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  function automatic logic [EW-1:0] sat32(input logic neg, input logic big,
                                          input logic [EW-1:0] mag);
    logic [EW-1:0] r;
    if (neg) begin
      if (big || mag > 32'h8000_0000) r = 32'h8000_0000;
      else r = -mag;
    end else begin
      if (big || mag[EW-1]) r = 32'h7FFF_FFFF;
      else r = mag;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/matrix_3x3_inverse.sv =====
// Top level of the 3x3 matrix inverse: cofactor and determinant stages feeding the divider.
// Depends on m3i_pkg and m3i_div_pipe.
//
// Usage: one 3x3 matrix of signed Q16.16 entries arrives per input beat on the s_axis
// channel; one result beat leaves on m_axis with the inverse (adjugate over the exact
// determinant, truncated toward zero and saturated), the saturated determinant and, in
// tuser, the singular flag. A singular matrix gives an all-zero tdata.
// Throughput is one beat per cycle unless a stall holds the pipeline. A beat passes through
// seven stages of products, cofactors, determinant and overflow checks, 32 divider stages
// each producing one quotient bit for all nine entries, and the output register.
// All stages advance together whenever the output register is empty or being taken, so
// s_axis_tready follows m_axis_tready while a result waits; a stall freezes the pipeline
// and nothing is lost or repeated.
// Reset clears every valid bit; no result is pending afterwards.
`default_nettype none
module matrix_3x3_inverse (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2, in_r2c0, in_r2c1, in_r2c2
  input  wire  [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // inv_r0c0 .. inv_r2c2 (row by row), det_value
  output logic [319:0] m_axis_tdata,
  // singular
  output logic [0:0]   m_axis_tuser
);
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [31:0] m [9];
  for (genvar k = 0; k < 9; k++) begin : g_m
    assign m[k] = s_axis_tdata[k*32 +: 32];
  end

  // Stage 1: two products per cofactor.
  logic               v1;
  logic signed [63:0] pa1 [9];
  logic signed [63:0] pb1 [9];
  logic signed [31:0] r0_1 [3];
  for (genvar k = 0; k < 9; k++) begin : g_prod
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int R1 = (R == 0) ? 1 : 0;
    localparam int R2 = (R == 2) ? 1 : 2;
    localparam int C1 = (C == 0) ? 1 : 0;
    localparam int C2 = (C == 2) ? 1 : 2;
    always_ff @(posedge clk) begin
      if (en) begin
        pa1[k] <= m[R1*3+C1] * m[R2*3+C2];
        pb1[k] <= m[R1*3+C2] * m[R2*3+C1];
      end
    end
  end

  // Stage 2: signed cofactors.
  logic               v2;
  logic signed [64:0] cof2 [9];
  logic signed [31:0] r0_2 [3];
  for (genvar k = 0; k < 9; k++) begin : g_cof
    logic signed [64:0] d;
    assign d = $signed({pa1[k][63], pa1[k]}) - $signed({pb1[k][63], pb1[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        cof2[k] <= (((k / 3) + (k % 3)) % 2 == 1) ? -d : d;
      end
    end
  end

  // Stage 3: partial products of row 0 with its cofactors.
  logic               v3;
  logic signed [64:0] cof3 [9];
  logic signed [65:0] pl3 [3];
  logic signed [63:0] ph3 [3];
  // Stage 4: the three expansion terms.
  logic               v4;
  logic signed [64:0] cof4 [9];
  logic signed [96:0] t4 [3];
  // Stage 5: determinant and cofactor magnitudes.
  logic               v5;
  logic signed [96:0] det5;
  logic [63:0]        amag5 [9];
  logic               aneg5 [9];
  // Stage 6: determinant magnitude and its saturated value.
  logic               v6;
  logic [95:0]        dmag6;
  logic               dneg6;
  logic               zero6;
  logic [31:0]        detv6;
  logic [63:0]        amag6 [9];
  logic               aneg6 [9];
  // Stage 7: overflow checks.
  logic                                v7;
  m3i_pkg::div_side_t                  side7;
  m3i_pkg::div_lane_t [m3i_pkg::NE-1:0] lane7;

  logic signed [96:0] det_sum;
  logic [95:0]        dmag_c;
  logic [63:0]        sh_c;
  assign det_sum = t4[0] + t4[1] + t4[2];
  assign dmag_c  = det5[96] ? 96'(-det5) : det5[95:0];
  assign sh_c    = dmag_c[95:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        r0_1[c] <= m[c];
        r0_2[c] <= r0_1[c];
        pl3[c]  <= r0_2[c] * $signed({1'b0, cof2[c][32:0]});
        ph3[c]  <= r0_2[c] * $signed(cof2[c][64:33]);
        t4[c]   <= $signed({ph3[c], 33'd0}) + $signed({{31{pl3[c][65]}}, pl3[c]});
      end
      for (int k = 0; k < 9; k++) begin
        cof3[k]  <= cof2[k];
        cof4[k]  <= cof3[k];
        amag5[k] <= cof4[k][64] ? 64'(-cof4[k]) : cof4[k][63:0];
        aneg5[k] <= cof4[k][64];
        amag6[k] <= amag5[k];
        aneg6[k] <= aneg5[k];
      end
      det5  <= det_sum;
      dmag6 <= dmag_c;
      dneg6 <= det5[96];
      zero6 <= (det5 == '0);
      detv6 <= m3i_pkg::sat32(det5[96], |sh_c[63:32], sh_c[31:0]);
      side7.dmag      <= dmag6;
      side7.singular  <= zero6;
      side7.det_value <= detv6;
      // Inverse entry (i,j) comes from cofactor (j,i).
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lane7[i*3+j].amag <= amag6[j*3+i];
          lane7[i*3+j].neg  <= aneg6[j*3+i] ^ dneg6;
          lane7[i*3+j].ovf  <= {32'd0, amag6[j*3+i]} >= dmag6;
        end
      end
    end
  end

  logic [m3i_pkg::NE-1:0][m3i_pkg::EW-1:0] inv;
  logic [m3i_pkg::EW-1:0]                  det_out;
  logic                                    sing_out;

  m3i_div_pipe u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (v7),
    .in_side      (side7),
    .in_lane      (lane7),
    .out_valid    (m_axis_tvalid),
    .out_inv      (inv),
    .out_det      (det_out),
    .out_singular (sing_out)
  );

  assign m_axis_tdata = {det_out, inv};
  assign m_axis_tuser = sing_out;
endmodule
`default_nettype wire

// ===== rtl/core/m3i_div_pipe.sv =====
// Pipelined restoring divider: nine lanes share one divisor, one quotient bit per stage,
// with saturation in the final output register. Depends on m3i_pkg.
`default_nettype none
module m3i_div_pipe (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire                                   in_valid,
  input  m3i_pkg::div_side_t                    in_side,
  input  m3i_pkg::div_lane_t [m3i_pkg::NE-1:0]  in_lane,
  output logic                                  out_valid,
  output logic [m3i_pkg::NE-1:0][m3i_pkg::EW-1:0] out_inv,
  output logic [m3i_pkg::EW-1:0]                out_det,
  output logic                                  out_singular
);
  logic               v    [m3i_pkg::NSTEP+1];
  m3i_pkg::div_side_t side [m3i_pkg::NSTEP+1];
  logic [m3i_pkg::MW-1:0]    rem [m3i_pkg::NSTEP+1][m3i_pkg::NE];
  logic [m3i_pkg::NSTEP-1:0] qv  [m3i_pkg::NSTEP+1][m3i_pkg::NE];
  logic               neg  [m3i_pkg::NSTEP+1][m3i_pkg::NE];
  logic               ovf  [m3i_pkg::NSTEP+1][m3i_pkg::NE];

  assign v[0]    = in_valid;
  assign side[0] = in_side;

  for (genvar l = 0; l < m3i_pkg::NE; l++) begin : g_in
    assign rem[0][l] = {{(m3i_pkg::MW-m3i_pkg::AW){1'b0}}, in_lane[l].amag};
    assign qv[0][l]  = '0;
    assign neg[0][l] = in_lane[l].neg;
    assign ovf[0][l] = in_lane[l].ovf;
  end

  for (genvar k = 0; k < m3i_pkg::NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
      end
    end
    for (genvar l = 0; l < m3i_pkg::NE; l++) begin : g_lane
      logic [m3i_pkg::MW:0] shifted;
      logic [m3i_pkg::MW:0] diff;
      assign shifted = {rem[k][l], 1'b0};
      assign diff    = shifted - {1'b0, side[k].dmag};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][l] <= diff[m3i_pkg::MW] ? shifted[m3i_pkg::MW-1:0]
                                           : diff[m3i_pkg::MW-1:0];
          qv[k+1][l]  <= {qv[k][l][m3i_pkg::NSTEP-2:0], ~diff[m3i_pkg::MW]};
          neg[k+1][l] <= neg[k][l];
          ovf[k+1][l] <= ovf[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[m3i_pkg::NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_det      <= side[m3i_pkg::NSTEP].det_value;
      out_singular <= side[m3i_pkg::NSTEP].singular;
      for (int l = 0; l < m3i_pkg::NE; l++) begin
        if (side[m3i_pkg::NSTEP].singular) begin
          out_inv[l] <= '0;
        end else begin
          out_inv[l] <= m3i_pkg::sat32(neg[m3i_pkg::NSTEP][l], ovf[m3i_pkg::NSTEP][l],
                                       qv[m3i_pkg::NSTEP][l]);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/m3i_checker.sv =====
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
// Depends on matrix_3x3_inverse_defines.svh.
`default_nettype none
`include "matrix_3x3_inverse_defines.svh"
module m3i_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [319:0] m_axis_tdata,
  input wire [0:0]   m_axis_tuser
);
  `M3I_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `M3I_ASSERT(a_singular_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
  `M3I_ASSERT_ALWAYS(a_reset_clear, rst |=> !m_axis_tvalid)
  `M3I_ASSERT_ALWAYS(a_ready_free, !m_axis_tvalid |-> s_axis_tready)
endmodule

bind matrix_3x3_inverse m3i_checker u_m3i_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
